// ----- rtl/core/brq_pkg.sv -----
package brq_pkg;

    // Fixed field widths of the item and result beats
    localparam int ID_W    = 5;
    localparam int LEVEL_W = 6;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [LEVEL_W-1:0] level_t;

    // Request codes; any other code only reports the best entry
    localparam mode_t MODE_ADD    = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_PEEK   = 2'd2;

    // Result status codes
    localparam status_t STATUS_OK         = 2'd0;
    localparam status_t STATUS_DUP_ADD    = 2'd1;
    localparam status_t STATUS_NOT_QUEUED = 2'd2;

    typedef struct packed {
        mode_t  mode;
        id_t    entry_id;
        level_t level;
    } in_t;

    typedef struct packed {
        logic    found;
        id_t     best_id;
        level_t  best_level;
        status_t status;
    } out_t;

endpackage

// ----- rtl/core/brq_state.sv -----
module brq_state #(
    parameter int NUM_LEVELS  = 64,
    parameter int MAX_ENTRIES = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        apply,
    input  brq_pkg::in_t                item,
    output brq_pkg::status_t            status,
    output logic [MAX_ENTRIES-1:0]      queued_reg,
    output brq_pkg::level_t             entry_level_reg [MAX_ENTRIES],
    output logic [MAX_ENTRIES-1:0]      older_reg [MAX_ENTRIES],
    output logic [NUM_LEVELS-1:0]       bitmap_reg
);

    localparam int ENT_IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    logic                   id_ok;
    logic [ENT_IDX_W-1:0]   ent;
    logic                   is_queued;
    brq_pkg::level_t        lv_sat;
    brq_pkg::level_t        cur_lv;
    logic [LVL_IDX_W-1:0]   add_idx;
    logic [LVL_IDX_W-1:0]   cur_idx;
    logic [MAX_ENTRIES-1:0] same_level;
    logic                   do_add;
    logic                   do_rem;
    logic [MAX_ENTRIES-1:0] queued_next;
    logic [NUM_LEVELS-1:0]  bitmap_next;
    logic [MAX_ENTRIES-1:0] older_next [MAX_ENTRIES];

    // Decode the request against the current entry table
    always_comb begin
        lv_sat = item.level;
        if (int'(item.level) >= NUM_LEVELS) begin
            lv_sat = brq_pkg::LEVEL_W'(NUM_LEVELS - 1);
        end
        id_ok     = int'(item.entry_id) < MAX_ENTRIES;
        ent       = ENT_IDX_W'(item.entry_id);
        is_queued = id_ok && queued_reg[ent];
        cur_lv    = entry_level_reg[ent];
        add_idx   = LVL_IDX_W'(lv_sat);
        cur_idx   = LVL_IDX_W'(cur_lv);

        do_add = (item.mode == brq_pkg::MODE_ADD) && id_ok && !is_queued;
        do_rem = (item.mode == brq_pkg::MODE_REMOVE) && is_queued;

        status = brq_pkg::STATUS_OK;
        if (item.mode == brq_pkg::MODE_ADD && is_queued) begin
            status = brq_pkg::STATUS_DUP_ADD;
        end else if (item.mode == brq_pkg::MODE_REMOVE && !is_queued) begin
            status = brq_pkg::STATUS_NOT_QUEUED;
        end
    end

    // Find other queued entries that share the removed entry's level
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            same_level[i] = queued_reg[i] && (entry_level_reg[i] == cur_lv)
                            && (ENT_IDX_W'(i) != ent);
        end
    end

    // Build next queued set and level bitmap
    always_comb begin
        queued_next = queued_reg;
        bitmap_next = bitmap_reg;
        if (do_add) begin
            queued_next[ent]     = 1'b1;
            bitmap_next[add_idx] = 1'b1;
        end else if (do_rem) begin
            queued_next[ent] = 1'b0;
            if (same_level == '0) begin
                bitmap_next[cur_idx] = 1'b0;
            end
        end
    end

    // Age matrix: row i marks entries added before i; an add makes the
    // new entry younger than everything queued and older than nobody
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            older_next[i]      = older_reg[i];
            older_next[i][ent] = 1'b0;
            if (ENT_IDX_W'(i) == ent) begin
                older_next[i] = queued_reg;
            end
        end
    end

    // Control state: queued flags and level bitmap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg <= '0;
            bitmap_reg <= '0;
        end else if (apply) begin
            queued_reg <= queued_next;
            bitmap_reg <= bitmap_next;
        end
    end

    // Payload: entry levels and age rows, written on add only
    always_ff @(posedge aclk) begin
        if (apply && do_add) begin
            entry_level_reg[ent] <= lv_sat;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                older_reg[i] <= older_next[i];
            end
        end
    end

endmodule

// ----- rtl/core/brq_select.sv -----
module brq_select #(
    parameter int NUM_LEVELS  = 64,
    parameter int MAX_ENTRIES = 32
) (
    input  logic [MAX_ENTRIES-1:0]  queued_reg,
    input  brq_pkg::level_t         entry_level_reg [MAX_ENTRIES],
    input  logic [MAX_ENTRIES-1:0]  older_reg [MAX_ENTRIES],
    input  logic [NUM_LEVELS-1:0]   bitmap_reg,
    output logic                    found,
    output brq_pkg::id_t            best_id,
    output brq_pkg::level_t         best_level
);

    localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    logic [LVL_IDX_W-1:0]   top_idx;
    logic [MAX_ENTRIES-1:0] cand;
    logic [MAX_ENTRIES-1:0] head;

    // Pick the highest populated level
    always_comb begin
        top_idx = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (bitmap_reg[k]) begin
                top_idx = LVL_IDX_W'(k);
            end
        end
        found      = |bitmap_reg;
        best_level = brq_pkg::LEVEL_W'(top_idx);
    end

    // Take the oldest queued entry of that level as its head
    always_comb begin
        best_id = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            cand[i] = queued_reg[i] && (entry_level_reg[i] == best_level) && found;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            head[i] = cand[i] && ((cand & older_reg[i]) == '0);
            if (head[i]) begin
                best_id = best_id | brq_pkg::ID_W'(i);
            end
        end
    end

endmodule

// ----- rtl/core/bitmap_priority_ready_queue.sv -----
// Priority ready queue: one FIFO of entries per level, highest level first.
// s_ channel: one beat per request (add, remove or peek of an entry id).
// m_ channel: exactly one result beat per request, in request order, with
// the head of the highest populated level and the request status.
// A request is registered at the input, applied to the entry table by the
// apply stage, and the best entry is then looked up from the updated table
// and registered in the result register.
// Each stage moves one beat per cycle, so while m_ready is high requests
// stream at one per cycle; the entry table is updated once per cycle by the
// apply stage, which is what sets that rate.
// When the receiver holds m_ready low, the stages fill up behind the result
// register and s_ready drops once all three hold a beat; nothing is dropped.
// Reset (aresetn low, synchronous) empties the queue and all stages; no
// clearing pass is needed, the queue is usable in the first cycle after.
module bitmap_priority_ready_queue #(
    parameter int NUM_LEVELS  = 64,
    parameter int MAX_ENTRIES = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  brq_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output brq_pkg::out_t m_data
);

    brq_pkg::in_t           in_reg;
    logic                   in_valid_reg;
    brq_pkg::status_t       status_reg;
    logic                   mid_valid_reg;
    brq_pkg::out_t          out_reg;
    logic                   out_valid_reg;

    logic                   out_ready;
    logic                   mid_ready;
    logic                   in_ready;
    logic                   apply;
    logic                   mid_move;

    brq_pkg::status_t       status;
    logic [MAX_ENTRIES-1:0] queued_reg;
    brq_pkg::level_t        entry_level_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] older_reg [MAX_ENTRIES];
    logic [NUM_LEVELS-1:0]  bitmap_reg;
    logic                   found;
    brq_pkg::id_t           best_id;
    brq_pkg::level_t        best_level;
    brq_pkg::out_t          out_next;

    // Advance each stage when the one downstream has room
    always_comb begin
        out_ready = !out_valid_reg || m_ready;
        mid_ready = !mid_valid_reg || out_ready;
        in_ready  = !in_valid_reg || mid_ready;
        apply     = in_valid_reg && mid_ready;
        mid_move  = mid_valid_reg && out_ready;
    end

    assign s_ready = in_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    brq_state #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_state (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .apply           (apply),
        .item            (in_reg),
        .status          (status),
        .queued_reg      (queued_reg),
        .entry_level_reg (entry_level_reg),
        .older_reg       (older_reg),
        .bitmap_reg      (bitmap_reg)
    );

    brq_select #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_select (
        .queued_reg      (queued_reg),
        .entry_level_reg (entry_level_reg),
        .older_reg       (older_reg),
        .bitmap_reg      (bitmap_reg),
        .found           (found),
        .best_id         (best_id),
        .best_level      (best_level)
    );

    // Assemble the result beat from the updated table
    always_comb begin
        out_next.found      = found;
        out_next.best_id    = best_id;
        out_next.best_level = best_level;
        out_next.status     = status_reg;
    end

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_ready) begin
                mid_valid_reg <= apply;
            end
            if (out_ready) begin
                out_valid_reg <= mid_move;
            end
        end
    end

    // Stage payloads: hold while stalled
    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (apply) begin
            status_reg <= status;
        end
        if (mid_move) begin
            out_reg <= out_next;
        end
    end

endmodule
